// ===== design/tsvf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvf_pkg
// Shared types, codes and saturation helpers for the cascaded
// state-variable filter.
// ----------------------------------------------------------------------------
package tsvf_pkg;

    // transaction payloads
    typedef struct packed {
        logic               kind;
        logic               channel;
        logic signed [31:0] sample_in;
        logic [1:0]         coef_stage;
        logic [1:0]         coef_select;
        logic [31:0]        coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_out;
        logic               out_channel;
        logic               clipped;
    } out_item_t;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    // coefficient selects
    localparam logic [1:0] COEF_G     = 2'd0;
    localparam logic [1:0] COEF_R     = 2'd1;
    localparam logic [1:0] COEF_H     = 2'd2;
    localparam logic [1:0] COEF_ALPHA = 2'd3;

    // responses
    localparam logic [1:0] RESP_LP    = 2'd0;
    localparam logic [1:0] RESP_BP    = 2'd1;
    localparam logic [1:0] RESP_HP    = 2'd2;
    localparam logic [1:0] RESP_NOTCH = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_STAGE_COUNT = 2'd0;
    localparam logic [1:0] CFG_RESPONSE    = 2'd1;
    localparam logic [1:0] CFG_ELLIPTIC    = 2'd2;

    typedef struct packed {
        logic [31:0] g;
        logic [31:0] r;
        logic [31:0] h;
        logic [31:0] al;
    } coef_set_t;

    // serial multiplier request and response
    typedef struct packed {
        logic               start;
        logic               uns;
        logic signed [32:0] a;
        logic [31:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic               clip;
        logic signed [31:0] value;
    } mul_rsp_t;

    // integrator memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] value;
    } sat_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_T,
        ST_T_W,
        ST_HP,
        ST_HP_W,
        ST_GH,
        ST_GH_W,
        ST_GB,
        ST_GB_W,
        ST_UPD,
        ST_A2,
        ST_A2_W,
        ST_MIX,
        ST_MIX_W,
        ST_DONE
    } seq_state_t;

    function automatic logic signed [33:0] sext34(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    // clamp a 34-bit sum to the signed 32-bit range
    function automatic sat_t sat34(input logic signed [33:0] v);
        sat_t r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r.clip  = 1'b0;
            r.value = v[31:0];
        end else begin
            r.clip  = 1'b1;
            r.value = v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== design/cascaded_tpt_svf_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_tpt_svf_filter
// Cascade of trapezoidal state-variable sections, Q8.24, saturating.
// ----------------------------------------------------------------------------
// One audio sample runs through the configured number of sections one after
// another. Every product goes through a single bit-serial multiplier that
// has a start step, one bit step per multiplier bit, a rounding step and a
// hand-over step, and each section needs four products plus fetch, load and
// update steps, with two more products in elliptic low-pass or high-pass mode.
// The next sample is accepted only after the last section and the done state,
// which waits while the output register is full; a coefficient load gives no
// result and leaves the sequencer idle. Load all coefficients of the sections
// in use before sending samples. The finished result sits in an output
// register, so the next transaction is taken while it waits for m_ready.
// Configuration writes are taken at any time but belong in idle periods.
// ----------------------------------------------------------------------------
module cascaded_tpt_svf_filter #(
    parameter int MAX_STAGES   = 4,
    parameter int NUM_CHANNELS = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input items
    input  logic                s_valid,
    output logic                s_ready,
    input  tsvf_pkg::in_item_t  s_data,
    // results
    output logic                m_valid,
    input  logic                m_ready,
    output tsvf_pkg::out_item_t m_data,
    // configuration writes
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int DEPTH = MAX_STAGES * NUM_CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // configuration registers
    logic [2:0] stage_count_reg;
    logic [1:0] response_reg;
    logic       elliptic_reg;

    // sequencer
    tsvf_pkg::seq_state_t state_reg, state_next;
    logic [SW-1:0]  stage_reg;
    logic [2:0]     last_stage_reg;
    logic           ch_reg;
    logic           clip_reg;
    logic           last_stage;

    // coefficient store, one row per section
    tsvf_pkg::coef_set_t coef_mem [MAX_STAGES];
    tsvf_pkg::coef_set_t coef_rd_reg;

    // working values of the current section
    logic signed [31:0] x_reg, s1_reg, s2_reg, d_reg;
    logic signed [31:0] hp_reg, gh_reg, bp_reg, gb_reg, lp_reg;
    logic [31:0]        damp_reg, a2_reg;

    // output register
    logic                m_valid_reg;
    tsvf_pkg::out_item_t m_data_reg;

    tsvf_pkg::mul_req_t  mul_req;
    tsvf_pkg::mul_rsp_t  mul_rsp;
    tsvf_pkg::mem_ctl_t  mem_ctl;
    logic [AW-1:0]       mem_addr;
    logic [63:0]         mem_rd;
    logic [63:0]         mem_wr;

    logic        s_accept;
    logic        out_free;
    logic [2:0]  stage_lim;
    logic [33:0] damp_sum;
    tsvf_pkg::sat_t sat_d, sat_bp, sat_lp, sat_s1n, sat_s2n, sat_notch, sat_mix;

    assign s_ready   = (state_reg == tsvf_pkg::ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // section count limited to the sections built
    assign stage_lim  = (32'(stage_count_reg) > MAX_STAGES) ? 3'(MAX_STAGES)
                                                            : stage_count_reg;
    assign last_stage = (32'(stage_reg) == 32'(last_stage_reg));
    assign mem_addr   = AW'(32'(stage_reg) * NUM_CHANNELS + 32'(ch_reg));

    // adders around the multiplier
    assign damp_sum  = {1'b0, coef_rd_reg.r, 1'b0} + {2'b00, coef_rd_reg.g};
    assign sat_d     = tsvf_pkg::sat34(tsvf_pkg::sext34(x_reg)
                                       - tsvf_pkg::sext34(mul_rsp.value)
                                       - tsvf_pkg::sext34(s2_reg));
    assign sat_bp    = tsvf_pkg::sat34(tsvf_pkg::sext34(mul_rsp.value)
                                       + tsvf_pkg::sext34(s1_reg));
    assign sat_lp    = tsvf_pkg::sat34(tsvf_pkg::sext34(mul_rsp.value)
                                       + tsvf_pkg::sext34(s2_reg));
    assign sat_s1n   = tsvf_pkg::sat34(tsvf_pkg::sext34(gh_reg)
                                       + tsvf_pkg::sext34(bp_reg));
    assign sat_s2n   = tsvf_pkg::sat34(tsvf_pkg::sext34(gb_reg)
                                       + tsvf_pkg::sext34(lp_reg));
    assign sat_notch = tsvf_pkg::sat34(tsvf_pkg::sext34(lp_reg)
                                       + tsvf_pkg::sext34(hp_reg));
    // elliptic mix: the chosen output plus alpha^2 times the opposite one
    assign sat_mix   = tsvf_pkg::sat34(
                           tsvf_pkg::sext34((response_reg == tsvf_pkg::RESP_LP)
                                            ? lp_reg : hp_reg)
                           + tsvf_pkg::sext34(mul_rsp.value));

    assign mem_wr = {sat_s1n.value, sat_s2n.value};

    tsvf_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    tsvf_state_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mem_ctl),
        .addr    (mem_addr),
        .wr_data (mem_wr),
        .rd_data (mem_rd)
    );

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_count_reg <= 3'd1;
            response_reg    <= tsvf_pkg::RESP_LP;
            elliptic_reg    <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tsvf_pkg::CFG_STAGE_COUNT: stage_count_reg <= cfg_data[2:0];
                tsvf_pkg::CFG_RESPONSE:    response_reg    <= cfg_data[1:0];
                tsvf_pkg::CFG_ELLIPTIC:    elliptic_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tsvf_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state, multiplier requests and memory control
    always_comb begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.uns   = 1'b0;
        mul_req.a     = {s1_reg[31], s1_reg};
        mul_req.b     = damp_reg;
        mem_ctl.rd_en = 1'b0;
        mem_ctl.wr_en = 1'b0;
        case (state_reg)
            tsvf_pkg::ST_IDLE: begin
                if (s_accept && s_data.kind == tsvf_pkg::KIND_SAMPLE
                        && 32'(s_data.channel) < NUM_CHANNELS) begin
                    // no sections in use: the sample passes unchanged
                    state_next = (stage_lim == 3'd0) ? tsvf_pkg::ST_DONE
                                                     : tsvf_pkg::ST_FETCH;
                end
            end
            tsvf_pkg::ST_FETCH: begin
                mem_ctl.rd_en = 1'b1;
                state_next    = tsvf_pkg::ST_LOAD;
            end
            tsvf_pkg::ST_LOAD: state_next = tsvf_pkg::ST_T;
            tsvf_pkg::ST_T: begin
                mul_req.start = 1'b1;
                state_next    = tsvf_pkg::ST_T_W;
            end
            tsvf_pkg::ST_T_W: begin
                if (mul_rsp.done) state_next = tsvf_pkg::ST_HP;
            end
            tsvf_pkg::ST_HP: begin
                mul_req.start = 1'b1;
                mul_req.a     = {d_reg[31], d_reg};
                mul_req.b     = coef_rd_reg.h;
                state_next    = tsvf_pkg::ST_HP_W;
            end
            tsvf_pkg::ST_HP_W: begin
                if (mul_rsp.done) state_next = tsvf_pkg::ST_GH;
            end
            tsvf_pkg::ST_GH: begin
                mul_req.start = 1'b1;
                mul_req.a     = {hp_reg[31], hp_reg};
                mul_req.b     = coef_rd_reg.g;
                state_next    = tsvf_pkg::ST_GH_W;
            end
            tsvf_pkg::ST_GH_W: begin
                if (mul_rsp.done) state_next = tsvf_pkg::ST_GB;
            end
            tsvf_pkg::ST_GB: begin
                mul_req.start = 1'b1;
                mul_req.a     = {bp_reg[31], bp_reg};
                mul_req.b     = coef_rd_reg.g;
                state_next    = tsvf_pkg::ST_GB_W;
            end
            tsvf_pkg::ST_GB_W: begin
                if (mul_rsp.done) state_next = tsvf_pkg::ST_UPD;
            end
            tsvf_pkg::ST_UPD: begin
                mem_ctl.wr_en = 1'b1;
                if (elliptic_reg && (response_reg == tsvf_pkg::RESP_LP
                                     || response_reg == tsvf_pkg::RESP_HP)) begin
                    state_next = tsvf_pkg::ST_A2;
                end else begin
                    state_next = last_stage ? tsvf_pkg::ST_DONE : tsvf_pkg::ST_FETCH;
                end
            end
            tsvf_pkg::ST_A2: begin
                mul_req.start = 1'b1;
                mul_req.uns   = 1'b1;
                mul_req.a     = {1'b0, coef_rd_reg.al};
                mul_req.b     = coef_rd_reg.al;
                state_next    = tsvf_pkg::ST_A2_W;
            end
            tsvf_pkg::ST_A2_W: begin
                if (mul_rsp.done) state_next = tsvf_pkg::ST_MIX;
            end
            tsvf_pkg::ST_MIX: begin
                mul_req.start = 1'b1;
                mul_req.a     = (response_reg == tsvf_pkg::RESP_LP)
                                ? {hp_reg[31], hp_reg} : {lp_reg[31], lp_reg};
                mul_req.b     = a2_reg;
                state_next    = tsvf_pkg::ST_MIX_W;
            end
            tsvf_pkg::ST_MIX_W: begin
                if (mul_rsp.done) begin
                    state_next = last_stage ? tsvf_pkg::ST_DONE : tsvf_pkg::ST_FETCH;
                end
            end
            tsvf_pkg::ST_DONE: begin
                if (out_free) state_next = tsvf_pkg::ST_IDLE;
            end
            default: state_next = tsvf_pkg::ST_IDLE;
        endcase
    end

    // coefficient store
    always_ff @(posedge aclk) begin
        if (s_accept && s_data.kind == tsvf_pkg::KIND_COEF
                && 32'(s_data.coef_stage) < MAX_STAGES) begin
            case (s_data.coef_select)
                tsvf_pkg::COEF_G:     coef_mem[SW'(s_data.coef_stage)].g  <= s_data.coef_value;
                tsvf_pkg::COEF_R:     coef_mem[SW'(s_data.coef_stage)].r  <= s_data.coef_value;
                tsvf_pkg::COEF_H:     coef_mem[SW'(s_data.coef_stage)].h  <= s_data.coef_value;
                tsvf_pkg::COEF_ALPHA: coef_mem[SW'(s_data.coef_stage)].al <= s_data.coef_value;
                default: ;
            endcase
        end
        if (state_reg == tsvf_pkg::ST_FETCH) begin
            coef_rd_reg <= coef_mem[stage_reg];
        end
    end

    // sequencer control: stage counter and clip flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= '0;
            clip_reg  <= 1'b0;
        end else begin
            case (state_reg)
                tsvf_pkg::ST_IDLE: begin
                    if (s_accept) begin
                        stage_reg <= '0;
                        clip_reg  <= 1'b0;
                    end
                end
                tsvf_pkg::ST_LOAD: clip_reg <= clip_reg | (damp_sum[33:32] != 2'b00);
                tsvf_pkg::ST_T_W: begin
                    if (mul_rsp.done) clip_reg <= clip_reg | mul_rsp.clip | sat_d.clip;
                end
                tsvf_pkg::ST_HP_W, tsvf_pkg::ST_A2_W: begin
                    if (mul_rsp.done) clip_reg <= clip_reg | mul_rsp.clip;
                end
                tsvf_pkg::ST_GH_W: begin
                    if (mul_rsp.done) clip_reg <= clip_reg | mul_rsp.clip | sat_bp.clip;
                end
                tsvf_pkg::ST_GB_W: begin
                    if (mul_rsp.done) clip_reg <= clip_reg | mul_rsp.clip | sat_lp.clip;
                end
                tsvf_pkg::ST_UPD: begin
                    clip_reg <= clip_reg | sat_s1n.clip | sat_s2n.clip
                                | (response_reg == tsvf_pkg::RESP_NOTCH && sat_notch.clip);
                    if (state_next == tsvf_pkg::ST_FETCH) stage_reg <= stage_reg + SW'(1);
                end
                tsvf_pkg::ST_MIX_W: begin
                    if (mul_rsp.done) begin
                        clip_reg <= clip_reg | mul_rsp.clip | sat_mix.clip;
                        if (!last_stage) stage_reg <= stage_reg + SW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // section datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            tsvf_pkg::ST_IDLE: begin
                if (s_accept) begin
                    x_reg          <= s_data.sample_in;
                    ch_reg         <= s_data.channel;
                    last_stage_reg <= stage_lim - 3'd1;
                end
            end
            tsvf_pkg::ST_LOAD: begin
                s1_reg   <= mem_rd[63:32];
                s2_reg   <= mem_rd[31:0];
                damp_reg <= (damp_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : damp_sum[31:0];
            end
            tsvf_pkg::ST_T_W:  if (mul_rsp.done) d_reg  <= sat_d.value;
            tsvf_pkg::ST_HP_W: if (mul_rsp.done) hp_reg <= mul_rsp.value;
            tsvf_pkg::ST_GH_W: begin
                if (mul_rsp.done) begin
                    gh_reg <= mul_rsp.value;
                    bp_reg <= sat_bp.value;
                end
            end
            tsvf_pkg::ST_GB_W: begin
                if (mul_rsp.done) begin
                    gb_reg <= mul_rsp.value;
                    lp_reg <= sat_lp.value;
                end
            end
            tsvf_pkg::ST_UPD: begin
                // section output feeds the next section
                case (response_reg)
                    tsvf_pkg::RESP_BP:    x_reg <= bp_reg;
                    tsvf_pkg::RESP_NOTCH: x_reg <= sat_notch.value;
                    tsvf_pkg::RESP_LP:    x_reg <= lp_reg;
                    default:              x_reg <= hp_reg;
                endcase
            end
            tsvf_pkg::ST_A2_W:  if (mul_rsp.done) a2_reg <= mul_rsp.value;
            tsvf_pkg::ST_MIX_W: if (mul_rsp.done) x_reg  <= sat_mix.value;
            default: ;
        endcase
    end

    // output register, parted from the sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == tsvf_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == tsvf_pkg::ST_DONE && out_free) begin
            m_data_reg.sample_out  <= x_reg;
            m_data_reg.out_channel <= ch_reg;
            m_data_reg.clipped     <= clip_reg;
        end
    end

`ifndef SYNTHESIS
    // multiplier results only arrive while the sequencer waits for one
    a_mul_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_rsp.done |-> (state_reg == tsvf_pkg::ST_T_W || state_reg == tsvf_pkg::ST_HP_W
                          || state_reg == tsvf_pkg::ST_GH_W || state_reg == tsvf_pkg::ST_GB_W
                          || state_reg == tsvf_pkg::ST_A2_W || state_reg == tsvf_pkg::ST_MIX_W))
        else $error("multiplier result outside a wait state");

    // a coefficient load never starts the sequencer
    a_coef_stays_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.kind == tsvf_pkg::KIND_COEF) |=> state_reg == tsvf_pkg::ST_IDLE)
        else $error("coefficient load left idle");

    // a result is only loaded from the done state
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == tsvf_pkg::ST_DONE)
        else $error("result loaded outside the done state");

    // the stage counter never passes the last section in use
    a_stage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tsvf_pkg::ST_FETCH) |-> 32'(stage_reg) <= 32'(last_stage_reg))
        else $error("stage counter beyond the last section");
`endif

endmodule

// ===== design/tsvf_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvf_serial_mul
// Bit-serial shift-add multiplier: signed 33-bit times unsigned 32-bit,
// one multiplier bit per cycle, then Q8.24 round half up and saturation.
// ----------------------------------------------------------------------------
module tsvf_serial_mul (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsvf_pkg::mul_req_t req,
    output tsvf_pkg::mul_rsp_t rsp
);

    logic               busy_reg;
    logic               fin_reg;
    logic               uns_reg;
    logic [4:0]         cnt_reg;
    logic signed [32:0] a_reg;
    logic [31:0]        b_reg;
    logic signed [33:0] hi_reg;
    logic [31:0]        lo_reg;
    logic               done_reg;
    logic               clip_reg;
    logic signed [31:0] value_reg;

    logic signed [33:0] hs;
    logic signed [65:0] prod;
    logic signed [65:0] rnd;
    logic signed [41:0] q;

    // partial product add for the current multiplier bit
    assign hs   = hi_reg + (b_reg[0] ? {a_reg[32], a_reg} : 34'sd0);
    assign prod = {hi_reg, lo_reg};
    assign rnd  = prod + 66'sd8388608;
    assign q    = rnd[65:24];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd31) begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end else if (fin_reg) begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            uns_reg <= req.uns;
            hi_reg  <= '0;
            lo_reg  <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            hi_reg  <= {hs[33], hs[33:1]};
            lo_reg  <= {hs[0], lo_reg[31:1]};
            b_reg   <= {1'b0, b_reg[31:1]};
            cnt_reg <= cnt_reg + 5'd1;
        end
        if (fin_reg) begin
            if (uns_reg) begin
                clip_reg  <= (q[41:32] != 10'd0);
                value_reg <= (q[41:32] != 10'd0) ? 32'hFFFF_FFFF : q[31:0];
            end else if (q[41:31] == 11'd0 || q[41:31] == 11'h7FF) begin
                clip_reg  <= 1'b0;
                value_reg <= q[31:0];
            end else begin
                clip_reg  <= 1'b1;
                value_reg <= q[41] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
        end
    end

    assign rsp = {done_reg, clip_reg, value_reg};

endmodule

// ===== design/tsvf_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvf_state_mem
// Integrator pair memory, one entry per section and channel, with
// per-entry valid bits so that unwritten entries read as zero.
// ----------------------------------------------------------------------------
module tsvf_state_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsvf_pkg::mem_ctl_t ctl,
    input  logic [AW-1:0]      addr,
    input  logic [63:0]        wr_data,
    output logic [63:0]        rd_data
);

    logic [63:0]      mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]      rd_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= valid_reg[addr] ? mem[addr] : 64'd0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cascaded state-variable filter: a directed
// table of samples and loads, then random traffic across register settings,
// each result checked field by field against a bit-accurate software filter.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSTG = 4;
    localparam int NCH  = 2;
    localparam longint LIMIT = 64'd20_000_000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    tsvf_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    tsvf_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    cascaded_tpt_svf_filter #(.MAX_STAGES(NSTG), .NUM_CHANNELS(NCH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // software copy of the filter state
    logic [31:0]         coef_mem [NSTG*4];
    longint              integ1 [NSTG*NCH];
    longint              integ2 [NSTG*NCH];
    logic [2:0]          n_stages;
    logic [1:0]          resp_sel;
    logic                ellip;
    bit                  clip_flag;
    tsvf_pkg::out_item_t pending_results[$];

    int   n_mismatch = 0;
    int   n_results = 0;
    int   n_sent = 0;
    longint cycles = 0;
    bit   hold_off = 1'b0;   // when set, forces m_ready high and so suppresses receiver stalls

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) begin clip_flag = 1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin clip_flag = 1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic longint satu32(longint v);
        if (v > 64'sd4294967295) begin clip_flag = 1; return 64'sd4294967295; end
        return v;
    endfunction

    // q8.24 product, round half up, saturated
    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b + 64'sd8388608;
        return sat32(p >>> 24);
    endfunction

    // runs one sample through the cascade, updates the integrators
    function automatic tsvf_pkg::out_item_t filter_sample(tsvf_pkg::in_item_t it);
        tsvf_pkg::out_item_t r;
        longint x, g, rr, h, al, s1, s2, damp, t, d, hp, gh, bp, gb, lp, a2;
        int stg, si;
        x = longint'(it.sample_in);
        clip_flag = 0;
        stg = (n_stages > NSTG) ? NSTG : n_stages;
        for (int k = 0; k < stg; k++) begin
            g  = longint'(coef_mem[k*4]);
            rr = longint'(coef_mem[k*4+1]);
            h  = longint'(coef_mem[k*4+2]);
            al = longint'(coef_mem[k*4+3]);
            si = k*NCH + it.channel;
            s1 = integ1[si];
            s2 = integ2[si];
            damp = satu32(2*rr + g);
            t  = qmul(s1, damp);
            d  = sat32(x - t - s2);
            hp = qmul(d, h);
            gh = qmul(hp, g);
            bp = sat32(gh + s1);
            gb = qmul(bp, g);
            lp = sat32(gb + s2);
            integ1[si] = sat32(gh + bp);
            integ2[si] = sat32(gb + lp);
            if (resp_sel == tsvf_pkg::RESP_BP) begin
                x = bp;
            end else if (resp_sel == tsvf_pkg::RESP_NOTCH) begin
                x = sat32(lp + hp);
            end else if (ellip) begin
                // al*al can exceed 2^63, keep it unsigned
                a2 = satu32(longint'((64'(unsigned'(al)) * 64'(unsigned'(al))
                                      + 64'd8388608) >> 24));
                if (resp_sel == tsvf_pkg::RESP_LP) x = sat32(lp + qmul(hp, a2));
                else x = sat32(hp + qmul(lp, a2));
            end else begin
                x = (resp_sel == tsvf_pkg::RESP_LP) ? lp : hp;
            end
        end
        r.sample_out  = x[31:0];
        r.out_channel = it.channel;
        r.clipped     = clip_flag;
        return r;
    endfunction

    task automatic note_item(tsvf_pkg::in_item_t it);
        if (it.kind == tsvf_pkg::KIND_COEF) begin
            coef_mem[it.coef_stage*4 + it.coef_select] = it.coef_value;
        end else begin
            pending_results.push_back(filter_sample(it));
        end
    endtask

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        tsvf_pkg::out_item_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result %h", m_data);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data !== exp_r) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp out=%h ch=%0d clip=%0d,",
                                  " got out=%h ch=%0d clip=%0d"},
                                 exp_r.sample_out, exp_r.out_channel, exp_r.clipped,
                                 m_data.sample_out, m_data.out_channel, m_data.clipped);
                end
            end
        end
    end

    // receiver stall pattern: a shifting mask with occasional free-run stretches
    logic [15:0] stall_mask = 16'hA5C3;
    int          free_run = 0;
    always @(posedge aclk) begin
        if (free_run > 0) begin
            free_run <= free_run - 1;
            m_ready <= 1'b1;
        end else begin
            m_ready <= stall_mask[0] | stall_mask[3] | hold_off;
            if ($urandom_range(0, 199) == 0)
                stall_mask <= 16'($urandom()) | 16'd1;
            else
                stall_mask <= {stall_mask[14:0], stall_mask[15] ^ stall_mask[13]};
            if ($urandom_range(0, 99) == 0) free_run <= $urandom_range(50, 400);
        end
    end

    // sends one transaction and records its expectation at acceptance;
    // valid stays high so a burst continues without a gap
    task automatic send(tsvf_pkg::in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        note_item(it);
        n_sent++;
    endtask

    // burst sender: random gaps between bursts
    int burst_left = 0;
    task automatic send_paced(tsvf_pkg::in_item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        send(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == tsvf_pkg::CFG_STAGE_COUNT) n_stages = val[2:0];
        else if (idx == tsvf_pkg::CFG_RESPONSE) resp_sel = val[1:0];
        else if (idx == tsvf_pkg::CFG_ELLIPTIC) ellip = val[0];
    endtask

    // let the block drain before touching registers
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    function automatic tsvf_pkg::in_item_t coef_item(int stg, logic [1:0] sel,
                                                     logic [31:0] v);
        tsvf_pkg::in_item_t it;
        it = '0;
        it.kind = tsvf_pkg::KIND_COEF;
        it.coef_stage = stg[1:0];
        it.coef_select = sel;
        it.coef_value = v;
        it.sample_in = $urandom();
        it.channel = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic tsvf_pkg::in_item_t sample_item(logic ch, logic [31:0] v);
        tsvf_pkg::in_item_t it;
        it = '0;
        it.kind = tsvf_pkg::KIND_SAMPLE;
        it.channel = ch;
        it.sample_in = v;
        it.coef_stage = 2'($urandom_range(0, 3));
        it.coef_select = 2'($urandom_range(0, 3));
        it.coef_value = $urandom();
        return it;
    endfunction

    // random coefficients: g, R, h and alpha in modest ranges, or full range when wild
    task automatic load_random_coefs(bit wild);
        for (int k = 0; k < NSTG; k++) begin
            send_paced(coef_item(k, tsvf_pkg::COEF_G,
                                 wild ? $urandom() : $urandom_range(0, 32'h0100_0000)));
            send_paced(coef_item(k, tsvf_pkg::COEF_R,
                                 wild ? $urandom() : $urandom_range(0, 32'h0200_0000)));
            send_paced(coef_item(k, tsvf_pkg::COEF_H,
                                 wild ? $urandom() : $urandom_range(0, 32'h0100_0000)));
            send_paced(coef_item(k, tsvf_pkg::COEF_ALPHA,
                                 wild ? $urandom() : $urandom_range(0, 32'h0200_0000)));
        end
    endtask

    // directed rows: expected value given only where obvious
    typedef struct {
        bit          is_coef;
        int          stg;
        logic [1:0]  sel;
        logic        ch;
        logic [31:0] val;
        bit          has_exp;
        logic [31:0] exp_out;
    } row_t;

    row_t dir_rows[$];

    initial begin
        tsvf_pkg::in_item_t it;
        int                 phase_items;
        for (int i = 0; i < NSTG*NCH; i++) begin integ1[i] = 0; integ2[i] = 0; end
        for (int i = 0; i < NSTG*4; i++) coef_mem[i] = '0;
        n_stages = 3'd1; resp_sel = tsvf_pkg::RESP_LP; ellip = 1'b0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // stage count zero: straight pass-through, value readable directly
        write_reg(tsvf_pkg::CFG_STAGE_COUNT, 32'd0);
        dir_rows = '{
            '{0, 0, tsvf_pkg::COEF_G, 0, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF},
            '{0, 0, tsvf_pkg::COEF_G, 1, 32'h8000_0000, 1, 32'h8000_0000},
            '{0, 0, tsvf_pkg::COEF_G, 0, 32'h0000_0000, 1, 32'h0000_0000},
            // coefficient loads for all four sections, zeros and extreme values among them
            '{1, 0, tsvf_pkg::COEF_G, 0, 32'h0000_0000, 0, 0},
            '{1, 0, tsvf_pkg::COEF_R, 0, 32'h0000_0000, 0, 0},
            '{1, 0, tsvf_pkg::COEF_H, 0, 32'hFFFF_FFFF, 0, 0},
            '{1, 0, tsvf_pkg::COEF_ALPHA, 0, 32'hFFFF_FFFF, 0, 0},
            '{1, 1, tsvf_pkg::COEF_G, 0, 32'hFFFF_FFFF, 0, 0},
            '{1, 1, tsvf_pkg::COEF_R, 0, 32'hFFFF_FFFF, 0, 0},
            '{1, 1, tsvf_pkg::COEF_H, 0, 32'h0100_0000, 0, 0},
            '{1, 1, tsvf_pkg::COEF_ALPHA, 0, 32'h0080_0000, 0, 0},
            '{1, 2, tsvf_pkg::COEF_G, 0, 32'h0040_0000, 0, 0},
            '{1, 2, tsvf_pkg::COEF_R, 0, 32'h00B5_0000, 0, 0},
            '{1, 2, tsvf_pkg::COEF_H, 0, 32'h00C0_0000, 0, 0},
            '{1, 2, tsvf_pkg::COEF_ALPHA, 0, 32'h0000_0000, 0, 0},
            '{1, 3, tsvf_pkg::COEF_G, 0, 32'h0100_0000, 0, 0},
            '{1, 3, tsvf_pkg::COEF_R, 0, 32'h0001_0000, 0, 0},
            '{1, 3, tsvf_pkg::COEF_H, 0, 32'h0080_0000, 0, 0},
            '{1, 3, tsvf_pkg::COEF_ALPHA, 0, 32'h0300_0000, 0, 0}
        };
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_coef)
                it = coef_item(dir_rows[i].stg, dir_rows[i].sel, dir_rows[i].val);
            else
                it = sample_item(dir_rows[i].ch, dir_rows[i].val);
            hold_off = 1'b0;
            send(it);
            if (dir_rows[i].has_exp && pending_results.size() != 0)
                pending_results[$].sample_out = dir_rows[i].exp_out;
        end
        drain();

        // large stage count saturates, extremes through all four sections
        write_reg(tsvf_pkg::CFG_STAGE_COUNT, 32'd7);
        write_reg(tsvf_pkg::CFG_RESPONSE, 32'(tsvf_pkg::RESP_HP));
        write_reg(tsvf_pkg::CFG_ELLIPTIC, 32'd1);
        send(sample_item(1'b0, 32'h7FFF_FFFF));
        send(sample_item(1'b1, 32'h8000_0000));
        send(sample_item(1'b0, 32'h0100_0000));
        drain();
        write_reg(tsvf_pkg::CFG_RESPONSE, 32'(tsvf_pkg::RESP_LP));
        send(sample_item(1'b1, 32'hFFFF_FFFF));
        drain();

        // random phases over register settings, extremes included
        for (int ph = 0; ph < 16; ph++) begin
            drain();
            write_reg(tsvf_pkg::CFG_STAGE_COUNT, (ph < 2) ? ph*4 : $urandom_range(0, 7));
            write_reg(tsvf_pkg::CFG_RESPONSE, ph % 4);
            write_reg(tsvf_pkg::CFG_ELLIPTIC, (ph / 4) % 2);
            load_random_coefs(ph % 5 == 4);
            phase_items = 40;
            for (int i = 0; i < phase_items; i++) begin
                if ($urandom_range(0, 9) == 0)
                    send_paced(coef_item($urandom_range(0, 3), 2'($urandom_range(0, 3)),
                                         $urandom_range(0, 32'h0100_0000)));
                else if ($urandom_range(0, 3) == 0)
                    send_paced(sample_item(1'($urandom_range(0, 1)), $urandom()));
                else
                    send_paced(sample_item(1'($urandom_range(0, 1)),
                                           $urandom_range(0, 32'h0400_0000) - 32'h0200_0000));
            end
        end

        drain();
        $display("items sent: %0d, results checked: %0d", n_sent, n_results);
        $display("covered all four responses with and without elliptic mix");
        if (n_mismatch == 0) begin
            $display("end of test: clean");
        end else begin
            $display("mismatch count: %0d", n_mismatch);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
